// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file linconv_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is muted while reset is asserted.
`define LC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define LC_ASSERT_NR(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/linconv_pkg.sv
`default_nettype none
package linconv_pkg;

    // Kernel length and datapath widths.
    localparam int MAX_TAPS = 16;
    localparam int DATA_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = 40;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int STAT_W   = 2;

    // Input item kinds.
    localparam logic MODE_TAP    = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_KERN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd2;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic                     step;
        logic                     clear;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: hw/rtl/linconv_if.sv
`default_nettype none
// Input channel: one tap or sample per transaction.
interface linconv_in_if;
    import linconv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] value;
    logic                     last;

    modport source (output valid, mode, value, last, input ready);
    modport sink   (input valid, mode, value, last, output ready);
endinterface

// Output channel: one convolution result per transaction.
interface linconv_out_if;
    import linconv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  result;
    logic                     end_of_output;
    logic [STAT_W-1:0]        status;

    modport source (output valid, result, end_of_output, status, input ready);
    modport sink   (input valid, result, end_of_output, status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/linconv_cell.sv
`default_nettype none
// One tap of the transposed-form filter: holds a coefficient and a partial sum.
module linconv_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  linconv_pkg::t_cell_ctl              i_ctl,
    input  logic                                i_load,
    input  logic                                i_active,
    input  logic                                i_nb_active,
    input  logic signed [linconv_pkg::ACC_W-1:0] i_nb_sum,
    output logic signed [linconv_pkg::ACC_W-1:0] o_sum
);
    import linconv_pkg::*;

    logic signed [DATA_W-1:0] r_tap;
    logic signed [ACC_W-1:0]  r_ps;
    logic signed [ACC_W-1:0]  n_ps;
    logic signed [PROD_W-1:0] w_prod;

    // Coefficient storage, written once per kernel load.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tap <= i_ctl.value;
        end
    end

    // Product of the broadcast sample with this tap; unused taps add nothing.
    assign w_prod = i_ctl.value * r_tap;
    assign o_sum  = i_active ? (r_ps + ACC_W'(w_prod)) : r_ps;

    // Partial sum takes the neighbor's sum on each step and empties past the kernel end.
    always_comb begin
        n_ps = r_ps;
        if (i_ctl.clear) begin
            n_ps = '0;
        end else if (i_ctl.step) begin
            n_ps = i_nb_active ? i_nb_sum : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps <= '0;
        end else begin
            r_ps <= n_ps;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/linear_convolution_top.sv
`default_nettype none
// A sample's result is in the output register in the cycle after its transaction.
// Throughput: one tap or sample per cycle while the output slot is free; the last sample
// of a sequence is followed by tap_count-1 flush results, during which no input is taken.
// The flush reuses the cell chain with a zero sample, so its length is set by the kernel.
// Reset (synchronous, active low) clears the partial sums, tap count and control state;
// taps are undefined until loaded.
module linear_convolution_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    linconv_in_if.sink    i_in,
    linconv_out_if.source o_out
);
    import linconv_pkg::*;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic                    r_state, n_state;
    logic [CNT_W-1:0]        r_tap_count, n_tap_count;
    logic                    r_kernel_done, n_kernel_done;
    logic [CNT_W-1:0]        r_flush_left, n_flush_left;

    logic                    r_out_valid, n_out_valid;
    logic signed [ACC_W-1:0] r_out_result, n_out_result;
    logic                    r_out_eoo, n_out_eoo;
    logic [STAT_W-1:0]       r_out_status, n_out_status;

    logic                    w_slot_free;
    logic                    w_in_fire;
    logic                    w_is_tap, w_is_smp;
    logic                    w_tap_full, w_tap_err, w_tap_store;
    logic                    w_smp_err, w_smp_go, w_flush_go;
    logic [CNT_W-1:0]        w_load_idx;
    t_cell_ctl               w_ctl;

    logic [MAX_TAPS:0]       w_active;
    logic [MAX_TAPS-1:0]     w_load;
    logic signed [ACC_W-1:0] w_sum [0:MAX_TAPS];

    // Input handshake and decode of the accepted transaction.
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_RUN) && w_slot_free;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_is_tap    = w_in_fire && (i_in.mode == MODE_TAP);
    assign w_is_smp    = w_in_fire && (i_in.mode == MODE_SAMPLE);

    assign w_tap_full  = !r_kernel_done && (r_tap_count == CNT_W'(MAX_TAPS));
    assign w_tap_err   = w_is_tap && w_tap_full;
    assign w_tap_store = w_is_tap && !w_tap_full;
    assign w_smp_err   = w_is_smp && (r_tap_count == '0);
    assign w_smp_go    = w_is_smp && (r_tap_count != '0);
    assign w_flush_go  = (r_state == ST_FLUSH) && w_slot_free;

    // A tap after a finished kernel restarts loading at the first cell.
    assign w_load_idx  = r_kernel_done ? '0 : r_tap_count;

    // Broadcast controls; the flush steps the chain with a zero sample.
    assign w_ctl.step  = w_smp_go || w_flush_go;
    assign w_ctl.clear = w_is_tap && r_kernel_done;
    assign w_ctl.value = w_flush_go ? '0 : i_in.value;

    // Per-cell load strobes and kernel membership.
    always_comb begin
        for (int k = 0; k < MAX_TAPS; k++) begin
            w_load[k]   = w_tap_store && (w_load_idx == CNT_W'(k));
            w_active[k] = CNT_W'(k) < r_tap_count;
        end
        w_active[MAX_TAPS] = 1'b0;
    end

    assign w_sum[MAX_TAPS] = '0;

    // Chain of cells, each passing its sum to the cell before it.
    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        linconv_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_load      (w_load[g]),
            .i_active    (w_active[g]),
            .i_nb_active (w_active[g+1]),
            .i_nb_sum    (w_sum[g+1]),
            .o_sum       (w_sum[g])
        );
    end

    // Kernel bookkeeping and flush sequencing.
    always_comb begin
        n_state       = r_state;
        n_tap_count   = r_tap_count;
        n_kernel_done = r_kernel_done;
        n_flush_left  = r_flush_left;
        if (w_is_tap) begin
            n_kernel_done = i_in.last;
            if (r_kernel_done) begin
                n_tap_count = CNT_W'(1);
            end else if (w_tap_store) begin
                n_tap_count = r_tap_count + CNT_W'(1);
            end
        end
        if (w_smp_go) begin
            n_kernel_done = 1'b1;
            if (i_in.last && (r_tap_count != CNT_W'(1))) begin
                n_state      = ST_FLUSH;
                n_flush_left = r_tap_count - CNT_W'(1);
            end
        end
        if (w_flush_go) begin
            n_flush_left = r_flush_left - CNT_W'(1);
            if (r_flush_left == CNT_W'(1)) begin
                n_state = ST_RUN;
            end
        end
    end

    // Output register: loads whenever its slot is free.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_result = r_out_result;
        n_out_eoo    = r_out_eoo;
        n_out_status = r_out_status;
        if (w_slot_free) begin
            n_out_valid  = w_smp_go || w_smp_err || w_tap_err || w_flush_go;
            n_out_result = (w_smp_go || w_flush_go) ? w_sum[0] : '0;
            n_out_eoo    = 1'b0;
            n_out_status = STAT_OK;
            if (w_smp_go) begin
                n_out_eoo = i_in.last && (r_tap_count == CNT_W'(1));
            end else if (w_flush_go) begin
                n_out_eoo = (r_flush_left == CNT_W'(1));
            end
            if (w_smp_err) begin
                n_out_status = STAT_NO_KERN;
            end else if (w_tap_err) begin
                n_out_status = STAT_TOO_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_RUN;
            r_tap_count   <= '0;
            r_kernel_done <= 1'b0;
            r_flush_left  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_tap_count   <= n_tap_count;
            r_kernel_done <= n_kernel_done;
            r_flush_left  <= n_flush_left;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_result <= n_out_result;
        r_out_eoo    <= n_out_eoo;
        r_out_status <= n_out_status;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result        = r_out_result;
    assign o_out.end_of_output = r_out_eoo;
    assign o_out.status        = r_out_status;

endmodule
`default_nettype wire

// File: hw/rtl/linconv_chk.sv
`default_nettype none
`include "assert_macros.svh"
// Port-level checks of the convolution block.
module linconv_chk (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_ready,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [linconv_pkg::ACC_W-1:0]  i_out_result,
    input  logic                                  i_out_eoo,
    input  logic [linconv_pkg::STAT_W-1:0]        i_out_status
);
    import linconv_pkg::*;

    // The output register is empty after reset.
    `LC_ASSERT_NR(a_reset_empty, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // Error results carry a zero value, no end mark and a defined code.
    `LC_ASSERT(a_err_clean, i_out_valid && i_out_status != STAT_OK |-> i_out_result == '0 && !i_out_eoo && (i_out_status == STAT_NO_KERN || i_out_status == STAT_TOO_LONG), "malformed error result")

    // No new transaction is taken while a result is stalled.
    `LC_ASSERT(a_stall_blocks, i_out_valid && !i_out_ready |-> !i_in_ready, "input taken during output stall")

    // A stalled result holds its value.
    `LC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result), "stalled result changed")

endmodule

bind linear_convolution_top linconv_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result),
    .i_out_eoo    (o_out.end_of_output),
    .i_out_status (o_out.status)
);
`default_nettype wire

// File: dv/linear_convolution_top_test.sv
`default_nettype none
module linear_convolution_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import linconv_pkg::*;

    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = MAX_TAPS + 8;
    localparam int MAX_GAP       = 12;
    localparam int HOLD_CYCLES   = 150;
    localparam int IDLE_PCT      = 26;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // One convolution output as it appears on the output channel.
    typedef struct packed {
        logic signed [ACC_W-1:0] result;
        logic                    end_of_output;
        logic [STAT_W-1:0]       status;
    } t_conv_out;

    logic clk = 1'b0;
    logic rst_n;

    linconv_in_if  in_if ();
    linconv_out_if out_if ();

    linear_convolution_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Convolution state tracked alongside the block.
    logic signed [DATA_W-1:0] kernel_taps  [MAX_TAPS];
    logic signed [ACC_W-1:0]  running_sums [MAX_TAPS];
    logic [CNT_W-1:0]         kernel_len;
    logic                     kernel_done;

    t_conv_out expected_outputs [$];

    int mismatch_count   = 0;
    int items_sent       = 0;
    int src_idle_pct     = IDLE_PCT;
    int sink_idle_pct    = IDLE_PCT;
    int sink_hold_cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_running_sums();
        foreach (running_sums[i]) running_sums[i] = '0;
    endfunction

    function automatic void expect_output(logic signed [ACC_W-1:0] value, logic eoo,
                                          logic [STAT_W-1:0] status);
        t_conv_out item;
        item.result        = value;
        item.end_of_output = eoo;
        item.status        = status;
        expected_outputs   = {expected_outputs, item};
    endfunction

    // Advance the transposed-form convolution by one accepted transaction.
    function automatic void predict_item(logic mode, logic signed [DATA_W-1:0] value,
                                         logic last);
        logic signed [ACC_W-1:0] sample_x;
        logic signed [ACC_W-1:0] tap_x;
        logic signed [ACC_W-1:0] first_out;
        int                      n;
        if (mode == MODE_TAP) begin
            // A tap after a finished kernel begins a fresh one.
            if (kernel_done) begin
                kernel_len  = '0;
                kernel_done = 1'b0;
                clear_running_sums();
            end
            if (kernel_len >= MAX_TAPS) begin
                if (last) kernel_done = 1'b1;
                expect_output('0, 1'b0, STAT_TOO_LONG);
                return;
            end
            kernel_taps[kernel_len] = value;
            kernel_len              = kernel_len + 1'b1;
            if (last) kernel_done = 1'b1;
            return;
        end
        if (kernel_len == 0) begin
            expect_output('0, 1'b0, STAT_NO_KERN);
            return;
        end
        kernel_done = 1'b1;
        n           = int'(kernel_len);
        sample_x    = ACC_W'(value);
        tap_x       = ACC_W'(kernel_taps[0]);
        first_out   = running_sums[0] + sample_x * tap_x;
        for (int j = 0; j + 1 < n; j++) begin
            tap_x           = ACC_W'(kernel_taps[j + 1]);
            running_sums[j] = running_sums[j + 1] + sample_x * tap_x;
        end
        running_sums[n - 1] = '0;
        expect_output(first_out, last && (n == 1), STAT_OK);
        // The final sample flushes the remaining partial sums.
        if (last) begin
            for (int j = 0; j + 1 < n; j++)
                expect_output(running_sums[j], (j + 2 == n), STAT_OK);
            clear_running_sums();
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        logic signed [DATA_W-1:0] v;
        v = DATA_W'($urandom);
        if ($urandom_range(7) == 0) v = ($urandom_range(1) != 0) ? VALUE_MAX : VALUE_MIN;
        return v;
    endfunction

    function automatic void report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t ns: mismatch: %s", $realtime, msg);
    endfunction

    // Compare one output transaction with the oldest expectation.
    function automatic void check_output();
        t_conv_out want;
        if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output result %0d end %0b status %0d",
                                      out_if.result, out_if.end_of_output, out_if.status));
            return;
        end
        want = expected_outputs.pop_front();
        if (out_if.result !== want.result || out_if.end_of_output !== want.end_of_output ||
            out_if.status !== want.status) begin
            report_mismatch($sformatf(
                "result exp %0d got %0d, end exp %0b got %0b, status exp %0d got %0d",
                want.result, out_if.result, want.end_of_output, out_if.end_of_output,
                want.status, out_if.status));
        end
    endfunction

    // Output side: check each transaction, then pick the next ready value.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
                check_output();
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one item after a random gap and wait until the block takes it.
    task automatic send_item(logic mode, logic signed [DATA_W-1:0] value, logic last);
        int gap;
        gap = 0;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct && gap < MAX_GAP)
            gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode  <= mode;
        in_if.value <= value;
        in_if.last  <= last;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        items_sent++;
        predict_item(mode, value, last);
    endtask

    // Stop offering input until every expected output has arrived.
    task automatic wait_for_outputs();
        in_if.valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge clk);
    endtask

    // A sample before any tap gives the no-kernel error.
    task automatic test_no_kernel();
        send_item(MODE_SAMPLE, VALUE_MIN, 1'b0);
        send_item(MODE_SAMPLE, 16'sd1234, 1'b1);
    endtask

    // One-tap kernel: the very first output of the last sample ends the sequence.
    task automatic test_single_tap();
        send_item(MODE_TAP, VALUE_MIN, 1'b1);
        send_item(MODE_SAMPLE, VALUE_MIN, 1'b0);
        send_item(MODE_SAMPLE, VALUE_MAX, 1'b0);
        send_item(MODE_SAMPLE, VALUE_MIN, 1'b1);
    endtask

    // Full kernel at the largest magnitudes, plus one tap too many that carries last.
    task automatic test_long_kernel();
        for (int i = 0; i < MAX_TAPS; i++)
            send_item(MODE_TAP, (i == MAX_TAPS - 1) ? VALUE_MAX : VALUE_MIN, 1'b0);
        send_item(MODE_TAP, VALUE_MAX, 1'b1);
        send_item(MODE_SAMPLE, VALUE_MIN, 1'b0);
        send_item(MODE_SAMPLE, VALUE_MAX, 1'b1);
    endtask

    // A sample ahead of the last tap closes the kernel; the next tap starts over.
    task automatic test_sample_before_last();
        send_item(MODE_TAP, 16'sd300, 1'b0);
        send_item(MODE_TAP, -16'sd7, 1'b0);
        send_item(MODE_SAMPLE, 16'sd1000, 1'b0);
        send_item(MODE_TAP, 16'sd5, 1'b1);
        send_item(MODE_SAMPLE, -16'sd2, 1'b1);
    endtask

    // Hold the output off for a long stretch while input keeps coming.
    task automatic test_output_hold();
        src_idle_pct     = 0;
        sink_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 6; i++) send_item(MODE_TAP, random_value(), i == 5);
        for (int i = 0; i < 30; i++) send_item(MODE_SAMPLE, random_value(), i == 29);
        src_idle_pct = IDLE_PCT;
    endtask

    // Mostly well-formed kernels and sample runs, with some broken sequences and noise.
    task automatic test_random_sequences();
        int start_count;
        int done_count;
        int kind;
        int n_taps;
        int n_samples;
        start_count = items_sent;
        done_count  = 0;
        while (done_count < RANDOM_ITEMS) begin
            // The middle third runs with no idling on either side.
            if (done_count > RANDOM_ITEMS / 3 && done_count < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = IDLE_PCT;
                sink_idle_pct = IDLE_PCT;
            end
            kind      = $urandom_range(9);
            n_taps    = ($urandom_range(7) == 0) ? $urandom_range(MAX_TAPS + 3, 1)
                                                 : $urandom_range(5, 1);
            n_samples = $urandom_range(12, 1);
            if (kind < 6) begin
                // Fresh kernel, then a sample sequence.
                for (int i = 0; i < n_taps; i++)
                    send_item(MODE_TAP, random_value(), i == n_taps - 1);
                for (int i = 0; i < n_samples; i++)
                    send_item(MODE_SAMPLE, random_value(), i == n_samples - 1);
            end else if (kind < 8) begin
                // Another sequence through the kernel already loaded.
                for (int i = 0; i < n_samples; i++)
                    send_item(MODE_SAMPLE, random_value(), i == n_samples - 1);
            end else if (kind == 8) begin
                // Kernel never marked last before the samples start.
                for (int i = 0; i < n_taps; i++) send_item(MODE_TAP, random_value(), 1'b0);
                for (int i = 0; i < n_samples; i++)
                    send_item(MODE_SAMPLE, random_value(), i == n_samples - 1);
            end else begin
                // Unstructured noise.
                repeat ($urandom_range(5, 1))
                    send_item(1'($urandom_range(1)), random_value(), 1'($urandom_range(1)));
            end
            done_count = items_sent - start_count;
        end
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    // Main sequence.
    initial begin
        rst_n       <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.mode  <= MODE_TAP;
        in_if.value <= '0;
        in_if.last  <= 1'b0;
        kernel_len  = '0;
        kernel_done = 1'b0;
        clear_running_sums();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_kernel();
        test_single_tap();
        test_long_kernel();
        test_sample_before_last();
        test_output_hold();
        wait_for_outputs();
        test_random_sequences();

        wait_for_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/linconv_pkg.sv
hw/rtl/linconv_if.sv
hw/rtl/linconv_cell.sv
hw/rtl/linear_convolution_top.sv
hw/rtl/linconv_chk.sv
dv/linear_convolution_top_test.sv
